[src/rational_arithmetic_unit_defines.svh]
// Assertion macros shared by the rational arithmetic unit RTL.
// No dependencies; clk and rst are taken from the module that uses them.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(lbl, prop, msg)
`define RAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/rau_pkg.sv]
// Package for the rational arithmetic unit: operation codes, sequencer
// states and result field widths. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int FUNC_W = 4;
  localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] FN_EQ  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_NE  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_LT  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_GT  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_LE  = 4'd8;
  localparam logic [FUNC_W-1:0] FN_GE  = 4'd9;

  localparam int RES_NUM_W   = 32;
  localparam int RES_DEN_W   = 31;
  localparam int OUT_BITS    = RES_NUM_W + RES_DEN_W + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
    ST_EVAL, ST_GCD, ST_DIV, ST_OUT
  } state_t;
endpackage

[src/rau_mul.sv]
// Shared signed multiplier with registered product.
// Depends on nothing but the operand width parameter.
`timescale 1ns / 1ps
module rau_mul #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[src/rau_gcd.sv]
// Binary gcd, one shift or subtract step per cycle.
// Operands must both be non-zero at start.
`timescale 1ns / 1ps
module rau_gcd #(
  parameter int MW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] x_in,
  input  logic [MW-1:0] y_in,
  output logic          done,
  output logic [MW-1:0] g
);
  localparam int KW = $clog2(MW + 1);
  logic [MW-1:0] x, y;
  logic [KW-1:0] k;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x_in;
        y    <= y_in;
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (x == '0) begin
          g    <= y << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (y == '0) begin
          g    <= x << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
    end
  end
endmodule

[src/rau_div.sv]
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Used to divide numerator and denominator magnitudes by their gcd.
`timescale 1ns / 1ps
module rau_div #(
  parameter int MW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] num0,
  input  logic [MW-1:0] num1,
  input  logic [MW-1:0] d,
  output logic          done,
  output logic [MW-1:0] q0,
  output logic [MW-1:0] q1
);
  localparam int CW = $clog2(MW + 1);
  logic [MW-1:0] q [2];
  logic [MW:0]   r [2];
  logic [MW-1:0] q_next [2];
  logic [MW:0]   r_next [2];
  logic [MW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;

  always_comb begin
    logic [MW:0] rr;
    rr = '0;
    for (int i = 0; i < 2; i++) begin
      rr = {r[i][MW-1:0], q[i][MW-1]};
      if (rr >= {1'b0, dv}) begin
        r_next[i] = rr - {1'b0, dv};
        q_next[i] = {q[i][MW-2:0], 1'b1};
      end else begin
        r_next[i] = rr;
        q_next[i] = {q[i][MW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q[0] <= num0;
        q[1] <= num1;
        r[0] <= '0;
        r[1] <= '0;
        dv   <= d;
        cnt  <= CW'(MW);
        busy <= 1'b1;
      end else if (busy) begin
        q[0] <= q_next[0];
        q[1] <= q_next[1];
        r[0] <= r_next[0];
        r[1] <= r_next[1];
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q0 = q[0];
  assign q1 = q[1];
endmodule

[src/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: sequencer around a shared multiplier,
// a binary gcd and a two-lane divider. Uses rau_pkg, rau_mul, rau_gcd, rau_div.
//
// Input stream s_axis: one transfer carries func and two fractions.
// Output stream m_axis: one transfer per input, the reduced fraction or the
// comparison flag and the divide-by-zero flag.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Sequence: the multiplier states ST_MUL0 to ST_MUL4, an evaluate state, then
// for an arithmetic result with a non-zero numerator the gcd (one shift or
// subtract a cycle) and the divider (one quotient bit a cycle), and finally
// the output register is loaded.
// The output register holds a result until taken; a stalled receiver holds
// the sequencer in its final state and keeps s_axis_tready low.
// Reset (rst, synchronous) returns the sequencer to idle and drops
// m_axis_tvalid.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // func, a_num, a_den, b_num, b_den from bit 0 up, zero padded
  input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // res_num, res_den, cmp_true, div_by_zero from bit 0 up, zero padded
  output logic [OUT_TDATA_W-1:0]                       m_axis_tdata
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;

  state_t state, state_next;

  logic [FUNC_W-1:0]    fn;
  logic signed [W-1:0]  an, bn;
  logic [W-2:0]         ad, bd;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod, p1, p2, pd, pn;

  logic                 gcd_start, gcd_done, div_start, div_done;
  logic [MW-1:0]        g, q0, q1, mag_n, mag_d;
  logic [MW-1:0]        mag_n_c, mag_d_c;
  logic                 neg;

  logic signed [MW-1:0] num_sel, den_sel, num_f, den_f;
  logic                 arith, cmp_sel, dz_sel;

  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic                        res_cmp, res_dz;
  logic                        accept_in;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept_in     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept_in) begin
      fn <= s_axis_tdata[FUNC_W-1:0];
      an <= s_axis_tdata[4 +: W];
      ad <= s_axis_tdata[4+W +: W-1];
      bn <= s_axis_tdata[3+2*W +: W];
      bd <= s_axis_tdata[3+3*W +: W-1];
    end
  end

  rau_mul #(.W(W)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  rau_gcd #(.MW(MW)) u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .x_in(mag_n_c), .y_in(mag_d_c),
    .done(gcd_done), .g(g)
  );

  rau_div #(.MW(MW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num0(mag_n), .num1(mag_d),
    .d(g), .done(div_done), .q0(q0), .q1(q1)
  );

  // evaluate the operation from the stored products
  always_comb begin
    num_sel = '0;
    den_sel = '0;
    arith   = 1'b0;
    cmp_sel = 1'b0;
    dz_sel  = 1'b0;
    case (fn)
      FN_ADD: begin
        num_sel = MW'(p1) + MW'(p2);
        den_sel = MW'(pd);
        arith   = 1'b1;
      end
      FN_SUB: begin
        num_sel = MW'(p1) - MW'(p2);
        den_sel = MW'(pd);
        arith   = 1'b1;
      end
      FN_MUL: begin
        num_sel = MW'(pn);
        den_sel = MW'(pd);
        arith   = 1'b1;
      end
      FN_DIV: begin
        if (bn == '0) begin
          dz_sel = 1'b1;
        end else begin
          num_sel = MW'(p1);
          den_sel = MW'(p2);
          arith   = 1'b1;
        end
      end
      FN_EQ:   cmp_sel = (p1 == p2);
      FN_NE:   cmp_sel = (p1 != p2);
      FN_LT:   cmp_sel = (p1 < p2);
      FN_GT:   cmp_sel = (p1 > p2);
      FN_LE:   cmp_sel = !(p1 > p2);
      FN_GE:   cmp_sel = !(p1 < p2);
      default: ;
    endcase
    num_f   = den_sel[MW-1] ? -num_sel : num_sel;
    den_f   = den_sel[MW-1] ? -den_sel : den_sel;
    mag_n_c = num_f[MW-1] ? MW'(-num_f) : MW'(num_f);
    mag_d_c = MW'(den_f);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept_in) state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_MUL4;
      ST_MUL4: state_next = ST_EVAL;
      ST_EVAL: begin
        if (arith && den_sel != '0 && num_f != '0) state_next = ST_GCD;
        else state_next = ST_OUT;
      end
      ST_GCD:  if (gcd_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = an;
    mul_b     = bn;
    gcd_start = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_MUL0: begin
        mul_a = an;
        mul_b = $signed({1'b0, bd});
      end
      ST_MUL1: begin
        mul_a = $signed({1'b0, ad});
        mul_b = bn;
      end
      ST_MUL2: begin
        mul_a = $signed({1'b0, ad});
        mul_b = $signed({1'b0, bd});
      end
      ST_EVAL: gcd_start = arith && den_sel != '0 && num_f != '0;
      ST_GCD:  div_start = gcd_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MUL1: p1 <= prod;
      ST_MUL2: p2 <= prod;
      ST_MUL3: pd <= prod;
      ST_MUL4: pn <= prod;
      ST_EVAL: begin
        res_cmp <= cmp_sel;
        res_dz  <= dz_sel;
        res_num <= '0;
        res_den <= (arith && den_sel != '0 && num_f == '0) ? RES_DEN_W'(1) : '0;
        neg     <= num_f[MW-1];
        mag_n   <= mag_n_c;
        mag_d   <= mag_d_c;
      end
      ST_DIV: begin
        if (div_done) begin
          res_num <= neg ? RES_NUM_W'(-$signed({1'b0, q0}))
                         : RES_NUM_W'($signed({1'b0, q0}));
          res_den <= RES_DEN_W'(q1);
        end
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= OUT_TDATA_W'({res_dz, res_cmp, res_den, res_num});
        end
      end
      default: ;
    endcase
  end

  `RAU_ASSERT(a_busy_after_accept, accept_in |=> !s_axis_tready, "took a second item")
  `RAU_ASSERT(a_dz_zero_result,
    m_axis_tvalid && m_axis_tdata[RES_NUM_W+RES_DEN_W+1] |->
    m_axis_tdata[RES_NUM_W+RES_DEN_W-1:0] == '0, "divide by zero with non-zero fraction")
  `RAU_ASSERT(a_cmp_no_den,
    m_axis_tvalid && m_axis_tdata[RES_NUM_W+RES_DEN_W] |->
    m_axis_tdata[RES_NUM_W +: RES_DEN_W] == '0, "comparison with a denominator")
  `RAU_ASSERT_ALWAYS(a_reset_idle, rst |=> s_axis_tready && !m_axis_tvalid, "not idle after reset")
endmodule
